// File: hw/rtl/swrm_pkg.sv
// Shared types and constants for the sliding-window RMS meter.
// Used by swrm_ctrl, swrm_dp and sliding_window_rms_meter; no dependencies.
`timescale 1ns / 1ps

package swrm_pkg;

    localparam int WINDOW_MAX_DEF  = 4096;
    localparam int CHANNELS_DEF    = 2;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int WIN_LEN_W   = 13;
    localparam int ACT_CH_W    = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_CH  = 1'b1;

    localparam logic [WIN_LEN_W-1:0] WINDOW_LEN_RST = 13'd2048;
    localparam logic [ACT_CH_W-1:0]  ACT_CH_RST     = 2'd2;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic mem_rd;
        logic update;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic out_load;
    } swrm_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic item_ok;
        logic last_flag;
        logic step_last;
        logic out_free;
    } swrm_sts_t;

endpackage

// File: hw/rtl/swrm_ctrl.sv
// Controller state machine of the sliding-window RMS meter.
// Sequences clearing, ring update, divide and square root; uses swrm_pkg.
`timescale 1ns / 1ps

module swrm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  swrm_pkg::swrm_sts_t sts,
    output swrm_pkg::swrm_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        sample_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    if (sts.item_ok)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = sts.last_flag ? ST_DIV_INIT : ST_IDLE;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.step_last)
                begin
                    state_next = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.step_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_write)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (state_reg == ST_CLEAR))
        else $error("configuration write did not start a clearing pass");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an untaken result");

    a_div_to_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && sts.step_last && !cfg_write) |=> (state_reg == ST_SQRT_INIT))
        else $error("divide end did not hand over to square root");

endmodule

// File: hw/rtl/swrm_dp.sv
// Datapath of the sliding-window RMS meter: configuration, per-channel state,
// square ring memory, bit-serial divider and square root. Uses swrm_pkg.
`timescale 1ns / 1ps

module swrm_dp
#(
    parameter int WINDOW_MAX  = swrm_pkg::WINDOW_MAX_DEF,
    parameter int CHANNELS    = swrm_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = swrm_pkg::SAMPLE_BITS_DEF,
    parameter int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [swrm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swrm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [CH_W-1:0]                     channel,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic                                block_end,
    input  logic                                result_ready,
    output logic                                result_valid,
    output logic [CH_W-1:0]                     out_channel,
    output logic [SAMPLE_BITS-1:0]              rms,
    input  swrm_pkg::swrm_cmd_t                 cmd,
    output swrm_pkg::swrm_sts_t                 sts
);

    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int POS_W  = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = SQ_W + POS_W;
    localparam int DEPTH  = CHANNELS * WINDOW_MAX;
    localparam int AW     = $clog2(DEPTH);
    localparam int RAD_W  = 2 * SAMPLE_BITS;
    localparam int STEP_W = $clog2(SQ_W);
    localparam int SB     = SAMPLE_BITS;

    logic [swrm_pkg::WIN_LEN_W-1:0] window_len_reg;
    logic [swrm_pkg::ACT_CH_W-1:0]  act_ch_reg;

    logic [SUM_W-1:0] sum_reg [CHANNELS];
    logic [POS_W-1:0] pos_reg [CHANNELS];
    logic [CNT_W-1:0] cnt_reg [CHANNELS];

    logic [AW-1:0]    clr_addr_reg;
    logic [CH_W-1:0]  ch_reg;
    logic             last_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [POS_W-1:0] pos_cur_reg;
    logic [SQ_W-1:0]  rd_data_reg;

    logic [CNT_W-1:0]  rem_reg;
    logic [SQ_W-1:0]   quo_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [SB-1:0]     root_reg;
    logic [SB+1:0]     srem_reg;
    logic [STEP_W-1:0] step_reg;

    logic            out_valid_reg;
    logic [CH_W-1:0] out_channel_reg;
    logic [SB-1:0]   rms_reg;

    logic [SQ_W-1:0] ring_mem [DEPTH];

    logic [CNT_W-1:0]  win;
    logic [SB-1:0]     sample_u;
    logic [SB-1:0]     mag;
    logic [2*SB-1:0]   sq_full;
    logic [POS_W-1:0]  pos_in;
    logic [POS_W-1:0]  pos_sel;
    logic [POS_W:0]    pos_inc;
    logic [AW-1:0]     item_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [SQ_W-1:0]   mem_wdata;
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_cur;
    logic [CNT_W:0]    div_t;
    logic              div_ge;
    logic [SB+3:0]     sq_t;
    logic [SB+3:0]     sq_trial;
    logic              sq_ge;

    always_comb
    begin
        if (32'(window_len_reg) > 32'(WINDOW_MAX))
        begin
            win = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            win = CNT_W'(window_len_reg);
        end
        sample_u = $unsigned(sample);
        mag      = sample_u[SB-1] ? (~sample_u + SB'(1)) : sample_u;
        sq_full  = mag * mag;
        pos_in   = pos_reg[channel];
        pos_sel  = (CNT_W'(pos_in) >= win) ? '0 : pos_in;
        pos_inc  = {1'b0, pos_cur_reg} + (POS_W + 1)'(1);
        item_addr = AW'(AW'(ch_reg) * AW'(WINDOW_MAX)) + AW'(pos_cur_reg);
        mem_we    = cmd.clr_step | cmd.update;
        mem_waddr = cmd.clr_step ? clr_addr_reg : item_addr;
        mem_wdata = cmd.clr_step ? '0 : sq_reg;
        sum_cur   = sum_reg[ch_reg];
        sum_next  = sum_cur - SUM_W'(rd_data_reg) + SUM_W'(sq_reg);
        div_t     = {rem_reg, quo_reg[SQ_W-1]};
        div_ge    = div_t >= {1'b0, div_reg};
        sq_t      = {srem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        sq_trial  = {2'b00, root_reg, 2'b01};
        sq_ge     = sq_t >= sq_trial;

        sts.clr_last  = (clr_addr_reg == AW'(DEPTH - 1));
        sts.item_ok   = (win != '0) && (32'(channel) < 32'(act_ch_reg))
                        && (32'(channel) < 32'(CHANNELS));
        sts.last_flag = last_reg;
        sts.step_last = (step_reg == '0);
        sts.out_free  = !out_valid_reg || result_ready;
    end

    // configuration and per-channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= swrm_pkg::WINDOW_LEN_RST;
            act_ch_reg     <= swrm_pkg::ACT_CH_RST;
            clr_addr_reg   <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
                pos_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                swrm_pkg::REG_WINDOW_LEN: window_len_reg <= cfg_data[swrm_pkg::WIN_LEN_W-1:0];
                swrm_pkg::REG_ACTIVE_CH:  act_ch_reg     <= cfg_data[swrm_pkg::ACT_CH_W-1:0];
                default:                  act_ch_reg     <= act_ch_reg;
            endcase
            clr_addr_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
                pos_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.update)
            begin
                sum_reg[ch_reg] <= sum_next;
                pos_reg[ch_reg] <= (CNT_W'(pos_inc) >= win) ? '0 : POS_W'(pos_inc);
                if (cnt_reg[ch_reg] < win)
                begin
                    cnt_reg[ch_reg] <= cnt_reg[ch_reg] + CNT_W'(1);
                end
            end
        end
    end

    // square ring
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= ring_mem[item_addr];
        end
    end

    // item capture, divider and square root
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg      <= channel;
            last_reg    <= block_end;
            sq_reg      <= sq_full[SQ_W-1:0];
            pos_cur_reg <= pos_sel;
        end
        if (cmd.div_init)
        begin
            rem_reg  <= CNT_W'(sum_cur[SUM_W-1:SQ_W]);
            quo_reg  <= sum_cur[SQ_W-1:0];
            div_reg  <= cnt_reg[ch_reg];
            step_reg <= STEP_W'(SQ_W - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= div_ge ? CNT_W'(div_t - {1'b0, div_reg}) : div_t[CNT_W-1:0];
            quo_reg  <= {quo_reg[SQ_W-2:0], div_ge};
            step_reg <= step_reg - STEP_W'(1);
        end
        else if (cmd.sqrt_init)
        begin
            rad_reg  <= RAD_W'(quo_reg);
            root_reg <= '0;
            srem_reg <= '0;
            step_reg <= STEP_W'(SB - 1);
        end
        else if (cmd.sqrt_step)
        begin
            srem_reg <= sq_ge ? (SB + 2)'(sq_t - sq_trial) : sq_t[SB+1:0];
            root_reg <= {root_reg[SB-2:0], sq_ge};
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_channel_reg <= ch_reg;
            rms_reg         <= root_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_channel  = out_channel_reg;
    assign rms          = rms_reg;

endmodule

// File: hw/rtl/sliding_window_rms_meter.sv
// Top level of the sliding-window RMS meter.
// Joins swrm_ctrl and swrm_dp; uses swrm_pkg.
//
// Input channel: sample_valid/sample_ready with channel, sample (signed Q1.15)
// and block_end. Result channel: result_valid/result_ready with out_channel
// and rms (floor RMS, Q1.15 magnitude). Configuration: cfg_write, cfg_index,
// cfg_data; index 0 is window_len, index 1 is active_channels.
// A sample without block_end passes through accept, ring read and ring update.
// A sample with block_end then adds divide set-up, a bit-serial divide,
// square-root set-up, a bit-serial square root and output load; the load
// waits for a free output register. Ignored samples are accepted and dropped.
// The ring memory has one port set, so each sample reads then writes it.
// After reset and after every configuration write a clearing pass zeroes all
// CHANNELS*WINDOW_MAX ring entries (8192 at the defaults), one entry a cycle,
// with sample_ready low throughout.
// A result waits in the output register while the receiver stalls; the next
// sample is still taken, and only a further result waits for the register.
`timescale 1ns / 1ps

module sliding_window_rms_meter
#(
    parameter int WINDOW_MAX  = swrm_pkg::WINDOW_MAX_DEF,
    parameter int CHANNELS    = swrm_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = swrm_pkg::SAMPLE_BITS_DEF,
    parameter int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [swrm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [swrm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  logic [CH_W-1:0]                  channel,
    input  logic signed [SAMPLE_BITS-1:0]    sample,
    input  logic                             block_end,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [CH_W-1:0]                  out_channel,
    output logic [SAMPLE_BITS-1:0]           rms
);

    swrm_pkg::swrm_cmd_t cmd;
    swrm_pkg::swrm_sts_t sts;

    swrm_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    swrm_dp
    #(
        .WINDOW_MAX  (WINDOW_MAX),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CH_W        (CH_W)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .channel      (channel),
        .sample       (sample),
        .block_end    (block_end),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .out_channel  (out_channel),
        .rms          (rms),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
